// ----- design/irpd_pkg.sv -----
// irpd_pkg: shared types, register map and timing match helper for the ir decoder
`timescale 1ns / 1ps

package irpd_pkg;

  // field widths of the transfers
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned DUR_W      = 24;
  localparam int unsigned SCAN_W     = 64;
  localparam int unsigned PROTO_W    = 8;
  localparam int unsigned TIME_W     = 16;
  localparam int unsigned BCNT_W     = 7;
  localparam int unsigned OPT_W      = 2;
  localparam int unsigned PDATA_W    = 64;
  localparam int unsigned PADDR_W    = 6;
  localparam int unsigned REG_IDX_W  = 3;

  // sample kinds
  localparam logic [MODE_W-1:0] MODE_SPACE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PULSE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OTHER   = 2'd3;

  // register indexes, byte address is 8 * index
  localparam logic [REG_IDX_W-1:0] REG_MARGIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HEADER   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BIT      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TRAILER  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BITCOUNT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_OPTIONS  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_PROTOCOL = 3'd7;

  // register reset values
  localparam logic [15:0] MARGIN_RST   = 16'd200;
  localparam logic [31:0] HEADER_RST   = 32'h0753_084D;
  localparam logic [31:0] REPEAT_RST   = 32'h0000_0000;
  localparam logic [47:0] BIT_RST      = 48'h0659_0177_0271;
  localparam logic [15:0] TRAILER_RST  = 16'd625;
  localparam logic [6:0]  BITCOUNT_RST = 7'd4;
  localparam logic [1:0]  OPTIONS_RST  = 2'd0;
  localparam logic [7:0]  PROTOCOL_RST = 8'd64;

  // option bits
  localparam int unsigned OPT_LSB_FIRST  = 0;
  localparam int unsigned OPT_NO_HEADER  = 1;

  // result kinds
  localparam logic EV_REPEAT  = 1'b0;
  localparam logic EV_KEYDOWN = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR_SPACE = 3'd1,
    PH_RPT_SPACE = 3'd2,
    PH_BIT_SPACE = 3'd3,
    PH_BIT_PULSE = 3'd4,
    PH_TRAILER   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DUR_W-1:0]  duration;
  } in_item_t;

  typedef struct packed {
    logic               event_res;
    logic [SCAN_W-1:0]  scancode;
    logic [PROTO_W-1:0] protocol_code;
  } out_item_t;

  // duration matches expected value: at least margin, and strictly within margin of it
  function automatic logic near_value(input logic [TIME_W-1:0] expect_val,
                                      input logic [DUR_W-1:0]  dur,
                                      input logic [TIME_W-1:0] margin);
    logic [DUR_W:0] e_plus;
    logic [DUR_W:0] d_plus;
    e_plus = {9'd0, expect_val} + {9'd0, margin};
    d_plus = {1'b0, dur} + {9'd0, margin};
    return ({8'd0, margin} <= dur) && (e_plus > {1'b0, dur}) && ({9'd0, expect_val} < d_plus);
  endfunction

endpackage

// ----- design/ir_pulse_distance_decoder.sv -----
// ir_pulse_distance_decoder: pulse-distance infrared frame decoder with apb register port
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------------
//   in_      | input     | in_valid/in_ready   | in_data: mode, duration
//   out_     | output    | out_valid/out_ready | out_data: event_res, scancode, protocol_code
//   apb      | input     | psel/penable/pready | paddr, pwdata, pwrite, prdata
//
// one sample per cycle sustained while results are taken; a sample goes into the input
// register on its transfer, is decoded from there and any result goes to the output register
// the throughput is set by the single phase/shift/count update done per decode cycle
// a full output register that is not taken holds the decode stage, which then holds in_ready
// rst_n is synchronous and active low; it restores all configuration registers to their defaults and
// empties both pipeline registers, no clearing pass is needed
`timescale 1ns / 1ps

module ir_pulse_distance_decoder #(
  parameter int unsigned SCANCODE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  irpd_pkg::in_item_t            in_data,
  // decoded results
  output logic                          out_valid,
  input  logic                          out_ready,
  output irpd_pkg::out_item_t           out_data,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [irpd_pkg::PADDR_W-1:0]  paddr,
  input  logic [irpd_pkg::PDATA_W-1:0]  pwdata,
  output logic [irpd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  import irpd_pkg::*;

  localparam int unsigned SW = SCANCODE_WIDTH;

  // configuration registers
  logic [15:0] margin_r;
  logic [31:0] header_r;
  logic [31:0] repeat_r;
  logic [47:0] bit_r;
  logic [15:0] trailer_r;
  logic [6:0]  bit_count_r;
  logic [1:0]  options_r;
  logic [7:0]  protocol_r;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  // pipeline and decode state
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  logic      res_valid;

  phase_t           phase_r, phase_nxt;
  logic [SW-1:0]    shift_r, shift_nxt;
  logic [6:0]       bit_index_r, bit_index_nxt;

  logic fire;
  logic active;
  logic is_pulse;

  // timing matches on the sample in the decode stage
  logic m_hdr_pulse, m_hdr_space, m_rpt_pulse, m_rpt_space;
  logic m_bit_pulse, m_zero, m_one, m_trailer;
  logic rpt_enabled;

  logic [SW-1:0] set_vec;
  logic [SW-1:0] shifted;
  logic [6:0]    index_inc;

  // ---------------------------------------------------------------- register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r    <= MARGIN_RST;
      header_r    <= HEADER_RST;
      repeat_r    <= REPEAT_RST;
      bit_r       <= BIT_RST;
      trailer_r   <= TRAILER_RST;
      bit_count_r <= BITCOUNT_RST;
      options_r   <= OPTIONS_RST;
      protocol_r  <= PROTOCOL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MARGIN:   margin_r    <= pwdata[15:0];
        REG_HEADER:   header_r    <= pwdata[31:0];
        REG_REPEAT:   repeat_r    <= pwdata[31:0];
        REG_BIT:      bit_r       <= pwdata[47:0];
        REG_TRAILER:  trailer_r   <= pwdata[15:0];
        REG_BITCOUNT: bit_count_r <= pwdata[6:0];
        REG_OPTIONS:  options_r   <= pwdata[1:0];
        REG_PROTOCOL: protocol_r  <= pwdata[7:0];
        default:      ;
      endcase
    end
  end

  // read back, zero extended to the bus width
  always_comb begin
    unique case (reg_idx)
      REG_MARGIN:   prdata = PDATA_W'(margin_r);
      REG_HEADER:   prdata = PDATA_W'(header_r);
      REG_REPEAT:   prdata = PDATA_W'(repeat_r);
      REG_BIT:      prdata = PDATA_W'(bit_r);
      REG_TRAILER:  prdata = PDATA_W'(trailer_r);
      REG_BITCOUNT: prdata = PDATA_W'(bit_count_r);
      REG_OPTIONS:  prdata = PDATA_W'(options_r);
      REG_PROTOCOL: prdata = PDATA_W'(protocol_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- input register
  // decode stage advances when the output register is free or being emptied
  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
  end

  // other samples pass through without touching the state
  assign active   = fire && (s1_item_r.mode != MODE_OTHER);
  // a timeout counts as a space
  assign is_pulse = (s1_item_r.mode == MODE_PULSE);

  // ---------------------------------------------------------------- duration matches
  assign rpt_enabled = (repeat_r[15:0] != 16'd0);
  assign m_hdr_pulse = near_value(header_r[15:0],  s1_item_r.duration, margin_r);
  assign m_hdr_space = near_value(header_r[31:16], s1_item_r.duration, margin_r);
  assign m_rpt_pulse = near_value(repeat_r[15:0],  s1_item_r.duration, margin_r);
  assign m_rpt_space = near_value(repeat_r[31:16], s1_item_r.duration, margin_r);
  assign m_bit_pulse = near_value(bit_r[15:0],     s1_item_r.duration, margin_r);
  assign m_zero      = near_value(bit_r[31:16],    s1_item_r.duration, margin_r);
  assign m_one       = near_value(bit_r[47:32],    s1_item_r.duration, margin_r);
  assign m_trailer   = near_value(trailer_r,       s1_item_r.duration, margin_r);

  // ---------------------------------------------------------------- bit insertion
  // lsb-first sets the bit at the current index, indexes past the code width drop out
  always_comb begin
    for (int i = 0; i < SW; i++) begin
      set_vec[i] = (bit_index_r == 7'(i));
    end
  end

  assign index_inc = bit_index_r + 7'd1;

  always_comb begin
    if (options_r[OPT_LSB_FIRST]) begin
      shifted = shift_r;
    end else begin
      shifted = {shift_r[SW-2:0], 1'b0};
    end
  end

  // ---------------------------------------------------------------- next phase
  always_comb begin
    phase_nxt = phase_r;
    if (active) begin
      unique case (phase_r)
        PH_HDR_SPACE: begin
          phase_nxt = (!is_pulse && m_hdr_space) ? PH_BIT_PULSE : PH_IDLE;
        end
        PH_RPT_SPACE: begin
          phase_nxt = (!is_pulse && m_rpt_space) ? PH_TRAILER : PH_IDLE;
        end
        PH_IDLE: begin
          // header beats repeat, repeat beats an absent header
          priority if (is_pulse && m_hdr_pulse) begin
            phase_nxt = PH_HDR_SPACE;
          end else if (is_pulse && rpt_enabled && m_rpt_pulse) begin
            phase_nxt = PH_RPT_SPACE;
          end else if (options_r[OPT_NO_HEADER]) begin
            phase_nxt = (is_pulse && m_bit_pulse) ? PH_BIT_SPACE : PH_IDLE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_BIT_PULSE: begin
          phase_nxt = (is_pulse && m_bit_pulse) ? PH_BIT_SPACE : PH_IDLE;
        end
        PH_BIT_SPACE: begin
          if (is_pulse || (!m_one && !m_zero)) begin
            phase_nxt = PH_IDLE;
          end else if (index_inc == bit_count_r) begin
            phase_nxt = PH_TRAILER;
          end else begin
            phase_nxt = PH_BIT_PULSE;
          end
        end
        PH_TRAILER: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- data and results
  always_comb begin
    shift_nxt     = shift_r;
    bit_index_nxt = bit_index_r;
    res_valid     = 1'b0;
    out_data_nxt  = out_data_r;
    if (active) begin
      unique case (phase_r)
        PH_IDLE: begin
          priority if (is_pulse && m_hdr_pulse) begin
            shift_nxt     = '0;
            bit_index_nxt = '0;
          end else if (is_pulse && rpt_enabled && m_rpt_pulse) begin
            bit_index_nxt = '0;
          end else if (options_r[OPT_NO_HEADER]) begin
            // header may be missing: start a fresh frame on this pulse
            shift_nxt     = '0;
            bit_index_nxt = '0;
          end else begin
            shift_nxt = shift_r;
          end
        end
        PH_BIT_SPACE: begin
          if (!is_pulse) begin
            if (m_one) begin
              shift_nxt = options_r[OPT_LSB_FIRST] ? (shifted | set_vec)
                                                   : (shifted | SW'(1));
            end else begin
              shift_nxt = shifted;
            end
            if (m_one || m_zero) begin
              bit_index_nxt = index_inc;
            end
          end
        end
        PH_TRAILER: begin
          if (is_pulse && m_trailer) begin
            res_valid = 1'b1;
            // no data bits means a repeat frame
            if (bit_index_r == 7'd0) begin
              out_data_nxt.event_res     = EV_REPEAT;
              out_data_nxt.scancode      = '0;
              out_data_nxt.protocol_code = '0;
            end else begin
              out_data_nxt.event_res     = EV_KEYDOWN;
              out_data_nxt.scancode      = SCAN_W'(shift_r);
              out_data_nxt.protocol_code = protocol_r;
            end
          end
        end
        default: begin
          shift_nxt = shift_r;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      shift_r     <= '0;
      bit_index_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bit_index_r <= bit_index_nxt;
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------- assertions
  a_result_from_trailer : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (phase_r == PH_TRAILER) && fire)
    else $error("result raised outside the trailer phase");

  a_repeat_is_blank : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.event_res == EV_REPEAT)) |->
      (out_data_r.scancode == '0) && (out_data_r.protocol_code == '0))
    else $error("repeat result carries data");

  a_header_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HDR_SPACE) |-> (bit_index_r == '0) && (shift_r == '0))
    else $error("header seen without a cleared frame");

  a_ready_only_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input held off without a stalled output");

  a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result lost or changed");

endmodule

// ----- test/tb_ir_pulse_distance_decoder.sv -----
// tb_ir_pulse_distance_decoder: self-checking bench for the pulse-distance ir frame decoder
`timescale 1ns / 1ps

module tb_ir_pulse_distance_decoder;
  import irpd_pkg::*;

  localparam int unsigned PHASE_COUNT   = 10;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned REPORT_LIMIT  = 10;
  // input register, decode stage and output register, with room to spare
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  localparam int unsigned DIRECTED_ROWS = 22;

  // one line of the directed table: the sample, and a typed-in result where one is obvious
  typedef struct packed {
    in_item_t  smp;
    logic      chk;
    out_item_t res;
  } stim_row_t;

  localparam out_item_t NO_EVENT = '0;

  // reset timings: header 2125/1875, bit pulse 625, zero 375, one 1625, trailer 625,
  // margin 200, four bits, msb first, protocol 64
  localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    {MODE_PULSE,   24'd0,        1'b0, NO_EVENT},   // shortest pulse while idle
    {MODE_PULSE,   24'hFFFFFF,   1'b0, NO_EVENT},   // longest pulse while idle
    {MODE_OTHER,   24'hFFFFFF,   1'b0, NO_EVENT},   // ignored sample kind
    {MODE_PULSE,   24'd2125,     1'b0, NO_EVENT},   // header pulse
    {MODE_SPACE,   24'd1875,     1'b0, NO_EVENT},   // header space
    {MODE_PULSE,   24'd625,      1'b0, NO_EVENT},
    {MODE_SPACE,   24'd1625,     1'b0, NO_EVENT},   // one
    {MODE_PULSE,   24'd824,      1'b0, NO_EVENT},   // just inside the margin
    {MODE_TIMEOUT, 24'd375,      1'b0, NO_EVENT},   // timeout taken as a zero space
    {MODE_PULSE,   24'd625,      1'b0, NO_EVENT},
    {MODE_OTHER,   24'd0,        1'b0, NO_EVENT},   // ignored in mid frame
    {MODE_SPACE,   24'd1426,     1'b0, NO_EVENT},   // one, low edge of the margin
    {MODE_PULSE,   24'd625,      1'b0, NO_EVENT},
    {MODE_SPACE,   24'd1625,     1'b0, NO_EVENT},   // one
    {MODE_PULSE,   24'd625,      1'b1, EV_KEYDOWN, 64'hB, PROTOCOL_RST},
    {MODE_PULSE,   24'd2125,     1'b0, NO_EVENT},
    {MODE_TIMEOUT, 24'd1875,     1'b0, NO_EVENT},   // timeout as header space
    {MODE_PULSE,   24'd625,      1'b0, NO_EVENT},
    {MODE_SPACE,   24'd575,      1'b0, NO_EVENT},   // exactly one margin off: frame drops
    {MODE_PULSE,   24'd625,      1'b0, NO_EVENT},   // idle bit pulse with header required
    {MODE_SPACE,   24'd0,        1'b0, NO_EVENT},
    {MODE_PULSE,   24'd2325,     1'b0, NO_EVENT}    // header pulse just outside the margin
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // shadow copy of the register file
  logic [15:0]         cfg_margin   = MARGIN_RST;
  logic [31:0]         cfg_header   = HEADER_RST;
  logic [31:0]         cfg_repeat   = REPEAT_RST;
  logic [47:0]         cfg_bit      = BIT_RST;
  logic [15:0]         cfg_trailer  = TRAILER_RST;
  logic [6:0]          cfg_bitcount = BITCOUNT_RST;
  logic [1:0]          cfg_options  = OPTIONS_RST;
  logic [7:0]          cfg_protocol = PROTOCOL_RST;

  // decoder state as the bench sees it
  phase_t              rx_phase = PH_IDLE;
  logic [SCAN_W-1:0]   rx_bits  = '0;
  logic [6:0]          rx_count = '0;

  out_item_t           pending_events [$];
  in_item_t            frame_q [$];
  out_item_t           want_event;
  int unsigned         fail_count = 0;
  int unsigned         sent_count = 0;
  bit                  steady     = 1'b0;   // both sides run without gaps

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ir_pulse_distance_decoder #(
    .SCANCODE_WIDTH (SCAN_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // a duration fits when it is at least the margin and strictly within it of the nominal
  function automatic bit dur_fits(input logic [TIME_W-1:0] nominal,
                                  input logic [DUR_W-1:0] dur);
    int unsigned n;
    int unsigned d;
    int unsigned m;
    n = nominal;
    d = dur;
    m = cfg_margin;
    return (d >= m) && (n + m > d) && (n < d + m);
  endfunction

  // advance the frame state by one sample, returns 1 when a result comes out
  function automatic bit decode_sample(input in_item_t smp, output out_item_t res);
    bit                pulse;
    bit                keep;
    logic [SCAN_W-1:0] set_mask;
    res = '0;
    if (smp.mode == MODE_OTHER) return 1'b0;
    // a timeout behaves as a space
    pulse = (smp.mode == MODE_PULSE);
    case (rx_phase)
      PH_HDR_SPACE: begin
        rx_phase = (!pulse && dur_fits(cfg_header[31:16], smp.duration)) ?
                   PH_BIT_PULSE : PH_IDLE;
      end
      PH_RPT_SPACE: begin
        rx_phase = (!pulse && dur_fits(cfg_repeat[31:16], smp.duration)) ?
                   PH_TRAILER : PH_IDLE;
      end
      PH_IDLE: begin
        // header beats repeat, repeat beats a frame with no header
        if (pulse && dur_fits(cfg_header[15:0], smp.duration)) begin
          rx_bits  = '0;
          rx_count = '0;
          rx_phase = PH_HDR_SPACE;
        end else if (pulse && cfg_repeat[15:0] != 16'd0 &&
                     dur_fits(cfg_repeat[15:0], smp.duration)) begin
          rx_count = '0;
          rx_phase = PH_RPT_SPACE;
        end else if (cfg_options[OPT_NO_HEADER]) begin
          rx_bits  = '0;
          rx_count = '0;
          rx_phase = (pulse && dur_fits(cfg_bit[15:0], smp.duration)) ?
                     PH_BIT_SPACE : PH_IDLE;
        end
      end
      PH_BIT_PULSE: begin
        rx_phase = (pulse && dur_fits(cfg_bit[15:0], smp.duration)) ?
                   PH_BIT_SPACE : PH_IDLE;
      end
      PH_BIT_SPACE: begin
        if (pulse) begin
          rx_phase = PH_IDLE;
        end else begin
          set_mask = 64'd1;
          if (cfg_options[OPT_LSB_FIRST]) begin
            set_mask = (rx_count < 7'd64) ? (64'd1 << rx_count) : '0;
          end else begin
            rx_bits = rx_bits << 1;
          end
          // the long space is tried first, so overlapping windows read as one
          if (dur_fits(cfg_bit[47:32], smp.duration)) begin
            rx_bits = rx_bits | set_mask;
            keep    = 1'b1;
          end else begin
            keep = dur_fits(cfg_bit[31:16], smp.duration);
          end
          if (!keep) begin
            rx_phase = PH_IDLE;
          end else begin
            rx_count = rx_count + 7'd1;
            rx_phase = (rx_count == cfg_bitcount) ? PH_TRAILER : PH_BIT_PULSE;
          end
        end
      end
      PH_TRAILER: begin
        rx_phase = PH_IDLE;
        if (pulse && dur_fits(cfg_trailer, smp.duration)) begin
          // no bits collected means a repeat frame, reported with zero fields
          if (rx_count != 7'd0) begin
            res.event_res     = EV_KEYDOWN;
            res.scancode      = rx_bits;
            res.protocol_code = cfg_protocol;
          end else begin
            res.event_res = EV_REPEAT;
          end
          return 1'b1;
        end
      end
      default: begin
        rx_phase = PH_IDLE;
      end
    endcase
    return 1'b0;
  endfunction

  // a random duration that fits the nominal value, or the nominal itself if none can
  function automatic logic [DUR_W-1:0] pick_match(input logic [TIME_W-1:0] nominal);
    int unsigned lo;
    int unsigned hi;
    hi = nominal + cfg_margin;
    if (cfg_margin == 16'd0 || hi == 0) return DUR_W'(nominal);
    hi = hi - 1;
    lo = (nominal >= cfg_margin) ? nominal - cfg_margin + 1 : 0;
    if (lo < cfg_margin) lo = cfg_margin;
    if (lo > hi) return DUR_W'(nominal);
    return DUR_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [MODE_W-1:0] gap_mode();
    return ($urandom_range(0, 3) == 0) ? MODE_TIMEOUT : MODE_SPACE;
  endfunction

  function automatic logic [TIME_W-1:0] rand_timing();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'h0000;
      default: return TIME_W'($urandom_range(300, 20000));
    endcase
  endfunction

  // apb write: setup cycle, then access cycle; the register takes it on the access edge
  // psel stays high between back to back writes, the caller releases the bus
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MARGIN:   cfg_margin   = val[15:0];
      REG_HEADER:   cfg_header   = val[31:0];
      REG_REPEAT:   cfg_repeat   = val[31:0];
      REG_BIT:      cfg_bit      = val[47:0];
      REG_TRAILER:  cfg_trailer  = val[15:0];
      REG_BITCOUNT: cfg_bitcount = val[6:0];
      REG_OPTIONS:  cfg_options  = val[1:0];
      REG_PROTOCOL: cfg_protocol = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [15:0] m, input logic [31:0] h,
                              input logic [31:0] r, input logic [47:0] b,
                              input logic [15:0] t, input logic [6:0] c,
                              input logic [1:0] o, input logic [7:0] p);
    reg_write(REG_MARGIN,   PDATA_W'(m));
    reg_write(REG_HEADER,   PDATA_W'(h));
    reg_write(REG_REPEAT,   PDATA_W'(r));
    reg_write(REG_BIT,      PDATA_W'(b));
    reg_write(REG_TRAILER,  PDATA_W'(t));
    reg_write(REG_BITCOUNT, PDATA_W'(c));
    reg_write(REG_OPTIONS,  PDATA_W'(o));
    reg_write(REG_PROTOCOL, PDATA_W'(p));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one sample transfer; the prediction is made on the accepting edge
  task automatic send_sample(input in_item_t smp, input bit fixed, input out_item_t fixed_res);
    int        gap;
    bit        has;
    out_item_t pred;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= smp;
    do @(posedge clk); while (!in_ready);
    has = decode_sample(smp, pred);
    if (fixed) begin
      pending_events.push_back(fixed_res);
    end else if (has) begin
      pending_events.push_back(pred);
    end
    if (smp.mode != MODE_OTHER) sent_count++;
  endtask

  // hold the sender until every result is out and the pipeline has emptied
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // queue a sample, now and then followed by one the decoder must ignore
  task automatic add_sample(input logic [MODE_W-1:0] m, input logic [DUR_W-1:0] d);
    frame_q.push_back({m, d});
    if ($urandom_range(0, 11) == 0) frame_q.push_back({MODE_OTHER, DUR_W'($urandom)});
  endtask

  task automatic build_keydown(input bit with_header);
    if (with_header) begin
      add_sample(MODE_PULSE, pick_match(cfg_header[15:0]));
      add_sample(gap_mode(), pick_match(cfg_header[31:16]));
    end
    for (int i = 0; i < cfg_bitcount; i++) begin
      add_sample(MODE_PULSE, pick_match(cfg_bit[15:0]));
      add_sample(gap_mode(),
                 pick_match($urandom_range(0, 1) ? cfg_bit[47:32] : cfg_bit[31:16]));
    end
    add_sample(MODE_PULSE, pick_match(cfg_trailer));
  endtask

  task automatic build_repeat();
    add_sample(MODE_PULSE, pick_match(cfg_repeat[15:0]));
    add_sample(gap_mode(), pick_match(cfg_repeat[31:16]));
    add_sample(MODE_PULSE, pick_match(cfg_trailer));
  endtask

  task automatic build_noise(input int n);
    for (int i = 0; i < n; i++) begin
      frame_q.push_back({MODE_W'($urandom_range(MODE_SPACE, MODE_OTHER)),
                         $urandom_range(0, 1) ? DUR_W'($urandom)
                                              : DUR_W'($urandom_range(0, 70000))});
    end
  endtask

  // spoil one sample of a queued frame, sometimes cutting the frame short there
  task automatic corrupt_frame();
    int idx;
    idx = $urandom_range(0, frame_q.size() - 1);
    case ($urandom_range(0, 2))
      0: frame_q[idx].duration = DUR_W'($urandom);
      1: frame_q[idx].duration = frame_q[idx].duration + DUR_W'(cfg_margin);
      default: frame_q[idx].mode = (frame_q[idx].mode == MODE_PULSE) ? MODE_SPACE : MODE_PULSE;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      while (frame_q.size() > idx + 1) void'(frame_q.pop_back());
    end
  endtask

  task automatic play_frame();
    foreach (frame_q[i]) send_sample(frame_q[i], 1'b0, NO_EVENT);
    frame_q.delete();
  endtask

  // result side: out_ready is sometimes held low before each transfer, never in steady phases
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // every result transfer is matched against the oldest outstanding prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("unexpected result: ev=%0d scan=%h proto=%h",
                   out_data.event_res, out_data.scancode, out_data.protocol_code);
        end
      end else begin
        want_event = pending_events.pop_front();
        if (out_data.event_res !== want_event.event_res ||
            out_data.scancode !== want_event.scancode ||
            out_data.protocol_code !== want_event.protocol_code) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("result mismatch: expected ev=%0d scan=%h proto=%h, got ev=%0d scan=%h proto=%h",
                     want_event.event_res, want_event.scancode, want_event.protocol_code,
                     out_data.event_res, out_data.scancode, out_data.protocol_code);
          end
        end
      end
    end
  end

  // main sequence: reset, directed table, then random phases under several settings
  initial begin
    int k;
    int kind;
    int phase_start;
    int waited;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part on the reset settings
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_sample(DIRECTED[i].smp, DIRECTED[i].chk, DIRECTED[i].res);
    end

    for (k = 0; k < PHASE_COUNT; k++) begin
      if (k > 0) begin
        settle();
        case (k)
          // widest margin: wide windows, but a duration must be at least the margin to fit
          1: load_setting(16'hFFFF, HEADER_RST, REPEAT_RST, BIT_RST, TRAILER_RST,
                          7'd3, 2'd0, 8'hA5);
          // repeat frames on, lsb first, optional header, single bit
          2: load_setting(16'd256, 32'h1194_2328, 32'h08CA_0BB8, 48'h0690_0230_0230,
                          16'd560, 7'd1, 2'd3, 8'hFF);
          // frame filling the whole scancode, with header timings at the top of their range
          3: load_setting(16'd300, 32'hFFFF_FFFF, REPEAT_RST, 48'h0BB8_03E8_03E8,
                          16'd1000, 7'd64, 2'd0, 8'h00);
          // zero margin: nothing can ever fit
          4: load_setting(16'd0, HEADER_RST, 32'h0753_084D, BIT_RST, TRAILER_RST,
                          7'd4, 2'd2, 8'h11);
          // repeat pulse equals bit pulse: repeat wins over a missing header
          5: load_setting(16'd200, HEADER_RST, 32'h0465_03E8, 48'h0659_0177_03E8,
                          16'd625, 7'd6, 2'd2, 8'h3C);
          // header pulse equals repeat pulse: header wins
          6: load_setting(16'd150, 32'h1194_2328, 32'h08CA_2328, 48'h0690_0230_0230,
                          16'd560, 7'd5, 2'd3, 8'h7E);
          default: load_setting(
                     ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(50, 600)),
                     {rand_timing(), rand_timing()},
                     ($urandom_range(0, 2) == 0) ? 32'd0 : {rand_timing(), rand_timing()},
                     {rand_timing(), rand_timing(), rand_timing()},
                     rand_timing(),
                     ($urandom_range(0, 5) == 0) ? 7'd64 : 7'($urandom_range(1, 12)),
                     2'($urandom_range(0, 3)),
                     8'($urandom));
        endcase
      end
      steady      = ($urandom_range(0, 3) == 0);
      phase_start = sent_count;
      // mostly well-formed frames with random timing, the rest broken frames and noise
      while (sent_count - phase_start < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        if (kind <= 5 || (kind <= 7 && cfg_repeat[15:0] == 16'd0)) begin
          build_keydown(!cfg_options[OPT_NO_HEADER] || $urandom_range(0, 1));
        end else if (kind <= 7) begin
          build_repeat();
        end else if (kind == 8) begin
          build_keydown(1'b1);
          corrupt_frame();
        end else begin
          build_noise($urandom_range(1, 4));
        end
        play_frame();
        // now and then let the pipeline run dry mid phase
        if ($urandom_range(0, 15) == 0) settle();
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    fail_count += pending_events.size();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/irpd_pkg.sv
design/ir_pulse_distance_decoder.sv
test/tb_ir_pulse_distance_decoder.sv
